// ===== hdl/sbx_pkg.sv =====
// Shared constants and types for the swept box edge crossing core.
// Holds the CORDIC arctangent table, the stage map of the pipeline and the
// register codes. Depends on nothing.
`default_nettype none

package sbx_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int COORD_W       = 32;
   localparam int HALF_W        = 30;
   localparam int ANGLE_W       = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_HALF_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF_WIDTH  = 2'd1;

   localparam int CORDIC_STEPS = 30;
   localparam int TRIG_BITS    = 30;
   localparam int TRIG_W       = 34;
   localparam int ZW           = 33;
   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      33'd536870912, 33'd316933406, 33'd167458907, 33'd85004756, 33'd42667331,
      33'd21354465, 33'd10679838, 33'd5340245, 33'd2670163, 33'd1335087,
      33'd667544, 33'd333772, 33'd166886, 33'd83443, 33'd41722,
      33'd20861, 33'd10430, 33'd5215, 33'd2608, 33'd1304,
      33'd652, 33'd326, 33'd163, 33'd81, 33'd41,
      33'd20, 33'd10, 33'd5, 33'd3, 33'd1
   };

   localparam int CORNERS  = 4;
   // Corners and obstacle edges walk the perimeter; a set bit negates the extent.
   localparam logic [CORNERS-1:0] CORNER_XNEG = 4'b1100;
   localparam logic [CORNERS-1:0] CORNER_YNEG = 4'b0110;
   localparam logic [CORNERS-1:0] DET_NEG     = 4'b0110;
   localparam logic [CORNERS-1:0] NT_NEG      = 4'b1001;

   localparam int CORNER_W = 34;
   localparam int OBS_W    = 33;
   localparam int DIFF_W   = 35;
   localparam int CMP_W    = 71;

   localparam int CORDIC_LAT = CORDIC_STEPS + 1;
   localparam int MUL_LAT    = 2;
   localparam int ST_PROD    = CORDIC_LAT + MUL_LAT;
   localparam int ST_CORNER  = ST_PROD + 1;
   localparam int ST_DIFF    = ST_CORNER + 1;
   localparam int ST_PROD2   = ST_DIFF + MUL_LAT;
   localparam int ST_SUB     = ST_PROD2 + 1;

   typedef struct packed {
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] sy;
      logic signed [COORD_W-1:0] ex;
      logic signed [COORD_W-1:0] ey;
      logic signed [COORD_W-1:0] ox;
      logic signed [COORD_W-1:0] oy;
   } pose_type;

endpackage

`default_nettype wire

// ===== hdl/sbx_mul.sv =====
// Two-stage signed multiplier, split into two partial products.
// Used for corner placement and the crossing products. No package needed.
`default_nettype none

module sbx_mul #(
   parameter int AW = 32,
   parameter int BW = 35
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic signed [AW-1:0] a,
   input  wire logic signed [BW-1:0] b,
   output logic signed [AW+BW-1:0]   p
);

   localparam int BLO = 18;
   localparam int BHI = BW - BLO;

   logic signed [AW+BLO:0]     lo_in, lo_ff;
   logic signed [AW+BHI-1:0]   hi_in, hi_ff;
   logic signed [AW+BW-1:0]    p_in, p_ff;

   assign lo_in = a * $signed({1'b0, b[BLO-1:0]});
   assign hi_in = a * $signed(b[BW-1:BLO]);
   assign p_in  = ((AW+BW)'(hi_ff) <<< BLO) + (AW+BW)'(lo_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         p_ff  <= p_in;
      end
   end

   assign p = p_ff;

endmodule

`default_nettype wire

// ===== hdl/sbx_cordic.sv =====
// Pipelined CORDIC giving cosine and sine of a binary angle in signed Q3.30.
// One rotation per stage plus an output stage. Uses sbx_pkg.
`default_nettype none

module sbx_cordic (
   input  wire logic                               clock,
   input  wire logic                               en,
   input  wire logic [sbx_pkg::ANGLE_W-1:0]        heading,
   output logic signed [sbx_pkg::TRIG_W-1:0]       cos_o,
   output logic signed [sbx_pkg::TRIG_W-1:0]       sin_o
);

   localparam int STEPS = sbx_pkg::CORDIC_STEPS;
   localparam int TW    = sbx_pkg::TRIG_W;
   localparam int ZW    = sbx_pkg::ZW;

   logic                 flip;
   logic signed [ZW-1:0] z_start;
   logic signed [TW-1:0] x_w [0:STEPS];
   logic signed [TW-1:0] y_w [0:STEPS];
   logic signed [ZW-1:0] z_w [0:STEPS];
   logic                 f_w [0:STEPS];
   logic signed [TW-1:0] cos_in, cos_ff, sin_in, sin_ff;

   // Headings in the second and third quadrants are turned by half a turn.
   assign flip    = heading[15] ^ heading[14];
   assign z_start = ZW'($signed({heading[15] ^ flip, heading[14:0], 16'b0}));

   assign x_w[0] = sbx_pkg::CORDIC_GAIN;
   assign y_w[0] = '0;
   assign z_w[0] = z_start;
   assign f_w[0] = flip;

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [TW-1:0] x_in, x_ff, y_in, y_ff;
      logic signed [ZW-1:0] z_in, z_ff;
      logic                 f_ff;

      always_comb begin
         if (!z_w[i][ZW-1]) begin
            x_in = x_w[i] - (y_w[i] >>> i);
            y_in = y_w[i] + (x_w[i] >>> i);
            z_in = z_w[i] - $signed(sbx_pkg::ATAN_TAB[i]);
         end else begin
            x_in = x_w[i] + (y_w[i] >>> i);
            y_in = y_w[i] - (x_w[i] >>> i);
            z_in = z_w[i] + $signed(sbx_pkg::ATAN_TAB[i]);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff <= x_in;
            y_ff <= y_in;
            z_ff <= z_in;
            f_ff <= f_w[i];
         end
      end

      assign x_w[i+1] = x_ff;
      assign y_w[i+1] = y_ff;
      assign z_w[i+1] = z_ff;
      assign f_w[i+1] = f_ff;
   end

   assign cos_in = f_w[STEPS] ? -x_w[STEPS] : x_w[STEPS];
   assign sin_in = f_w[STEPS] ? -y_w[STEPS] : y_w[STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_o = cos_ff;
   assign sin_o = sin_ff;

endmodule

`default_nettype wire

// ===== hdl/swept_box_edge_crossing_core.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  start and end poses, obstacle centre
// rsp_      out        rsp_valid/rsp_stall  hit
// csr_      in         csr_valid/csr_ready  register index and write data
//
// Top level of the swept box edge crossing core; uses sbx_pkg, sbx_cordic
// and sbx_mul. An item may enter every cycle while no result is stalled; most
// of the pipeline depth comes from the thirty CORDIC rotation stages.
// Reset is synchronous, clears the valid bits and sets both half extents to one.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
`default_nettype none

module swept_box_edge_crossing_core #(
   parameter int FRAC_BITS = sbx_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [sbx_pkg::COORD_W-1:0]   req_start_x,
   input  wire logic signed [sbx_pkg::COORD_W-1:0]   req_start_y,
   input  wire logic [sbx_pkg::ANGLE_W-1:0]          req_start_heading,
   input  wire logic signed [sbx_pkg::COORD_W-1:0]   req_end_x,
   input  wire logic signed [sbx_pkg::COORD_W-1:0]   req_end_y,
   input  wire logic [sbx_pkg::ANGLE_W-1:0]          req_end_heading,
   input  wire logic signed [sbx_pkg::COORD_W-1:0]   req_obstacle_x,
   input  wire logic signed [sbx_pkg::COORD_W-1:0]   req_obstacle_y,
   input  wire logic                                 req_obstacle_is_box,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_hit,

   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [sbx_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [sbx_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int HW     = sbx_pkg::HALF_W;
   localparam int TW     = sbx_pkg::TRIG_W;
   localparam int NC     = sbx_pkg::CORNERS;
   localparam int CW     = sbx_pkg::CORNER_W;
   localparam int OW     = sbx_pkg::OBS_W;
   localparam int DW     = sbx_pkg::DIFF_W;
   localparam int KW     = sbx_pkg::CMP_W;
   localparam int P1W    = HW + 1 + TW;
   localparam int SW     = P1W + 2;
   localparam int EW     = HW + 2;
   localparam int PDW    = EW + DW;
   localparam int PNW    = DW + DW;
   localparam int ST_PROD = sbx_pkg::ST_PROD;
   localparam int ST_SUB  = sbx_pkg::ST_SUB;
   localparam logic [HW-1:0]          HALF_RESET = HW'(64'd1 << FRAC_BITS);
   localparam logic signed [SW-1:0]   ROUND = SW'(64'd1 << (sbx_pkg::TRIG_BITS - 1));

   logic                    adv;
   logic                    rsp_valid_ff, rsp_hit_ff, rsp_hit_in;
   logic [HW-1:0]           half_length_ff, half_width_ff;
   logic [ST_SUB:0]         v_ff, v_in, box_ff, box_in;
   sbx_pkg::pose_type       pose_ff [0:ST_PROD];
   logic [sbx_pkg::ANGLE_W-1:0] hs_ff, he_ff;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_length_ff <= HALF_RESET;
         half_width_ff  <= HALF_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            sbx_pkg::REG_HALF_LENGTH: half_length_ff <= csr_wdata[HW-1:0];
            sbx_pkg::REG_HALF_WIDTH:  half_width_ff  <= csr_wdata[HW-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline control: every stage moves unless a result is held.
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign v_in      = {v_ff[ST_SUB-1:0], req_valid};
   assign box_in    = {box_ff[ST_SUB-1:0], req_obstacle_is_box};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         box_ff     <= box_in;
         hs_ff      <= req_start_heading;
         he_ff      <= req_end_heading;
         pose_ff[0] <= '{sx: req_start_x, sy: req_start_y, ex: req_end_x,
                         ey: req_end_y, ox: req_obstacle_x, oy: req_obstacle_y};
         for (int k = 1; k <= ST_PROD; k++) begin
            pose_ff[k] <= pose_ff[k-1];
         end
      end
   end

   // Trigonometry and the four products per pose.
   logic signed [TW-1:0]  trig_c [2];
   logic signed [TW-1:0]  trig_s [2];
   logic signed [P1W-1:0] lc [2];
   logic signed [P1W-1:0] ws [2];
   logic signed [P1W-1:0] ls [2];
   logic signed [P1W-1:0] wc [2];
   logic signed [HW:0]    l_s, w_s;

   assign l_s = $signed({1'b0, half_length_ff});
   assign w_s = $signed({1'b0, half_width_ff});

   sbx_cordic u_cordic_start (.clock(clock), .en(adv), .heading(hs_ff),
                              .cos_o(trig_c[0]), .sin_o(trig_s[0]));
   sbx_cordic u_cordic_end   (.clock(clock), .en(adv), .heading(he_ff),
                              .cos_o(trig_c[1]), .sin_o(trig_s[1]));

   for (genvar p = 0; p < 2; p++) begin : g_pose
      sbx_mul #(.AW(HW+1), .BW(TW)) u_lc (.clock(clock), .en(adv), .a(l_s),
                                         .b(trig_c[p]), .p(lc[p]));
      sbx_mul #(.AW(HW+1), .BW(TW)) u_ws (.clock(clock), .en(adv), .a(w_s),
                                         .b(trig_s[p]), .p(ws[p]));
      sbx_mul #(.AW(HW+1), .BW(TW)) u_ls (.clock(clock), .en(adv), .a(l_s),
                                         .b(trig_s[p]), .p(ls[p]));
      sbx_mul #(.AW(HW+1), .BW(TW)) u_wc (.clock(clock), .en(adv), .a(w_s),
                                         .b(trig_c[p]), .p(wc[p]));
   end

   // Corner placement and obstacle corners.
   logic signed [CW-1:0] cx_in [2][NC];
   logic signed [CW-1:0] cy_in [2][NC];
   logic signed [CW-1:0] cx_ff [2][NC];
   logic signed [CW-1:0] cy_ff [2][NC];
   logic signed [OW-1:0] bxp_in, bxm_in, byp_in, bym_in;
   logic signed [OW-1:0] bxp_ff, bxm_ff, byp_ff, bym_ff;

   always_comb begin
      logic signed [SW-1:0] ox_sum, oy_sum, t_lx, t_wx, t_ly, t_wy;
      logic signed [SW-1:0] sh_x, sh_y;
      logic signed [CW-1:0] bx, by;
      for (int p = 0; p < 2; p++) begin
         for (int j = 0; j < NC; j++) begin
            t_lx   = sbx_pkg::CORNER_XNEG[j] ? -SW'(lc[p]) : SW'(lc[p]);
            t_wx   = sbx_pkg::CORNER_YNEG[j] ? SW'(ws[p]) : -SW'(ws[p]);
            t_ly   = sbx_pkg::CORNER_XNEG[j] ? -SW'(ls[p]) : SW'(ls[p]);
            t_wy   = sbx_pkg::CORNER_YNEG[j] ? -SW'(wc[p]) : SW'(wc[p]);
            ox_sum = t_lx + t_wx + ROUND;
            oy_sum = t_ly + t_wy + ROUND;
            sh_x   = ox_sum >>> sbx_pkg::TRIG_BITS;
            sh_y   = oy_sum >>> sbx_pkg::TRIG_BITS;
            bx     = (p == 0) ? CW'(pose_ff[ST_PROD].sx) : CW'(pose_ff[ST_PROD].ex);
            by     = (p == 0) ? CW'(pose_ff[ST_PROD].sy) : CW'(pose_ff[ST_PROD].ey);
            cx_in[p][j] = bx + sh_x[CW-1:0];
            cy_in[p][j] = by + sh_y[CW-1:0];
         end
      end
   end

   assign bxp_in = OW'(pose_ff[ST_PROD].ox) + OW'(half_length_ff);
   assign bxm_in = OW'(pose_ff[ST_PROD].ox) - OW'(half_length_ff);
   assign byp_in = OW'(pose_ff[ST_PROD].oy) + OW'(half_width_ff);
   assign bym_in = OW'(pose_ff[ST_PROD].oy) - OW'(half_width_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         bxp_ff <= bxp_in;
         bxm_ff <= bxm_in;
         byp_ff <= byp_in;
         bym_ff <= bym_in;
      end
   end

   // Path directions and offsets from the obstacle corners.
   logic signed [DW-1:0] rx_ff [NC];
   logic signed [DW-1:0] ry_ff [NC];
   logic signed [DW-1:0] dxp_ff [NC];
   logic signed [DW-1:0] dxm_ff [NC];
   logic signed [DW-1:0] dyp_ff [NC];
   logic signed [DW-1:0] dym_ff [NC];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < NC; j++) begin
            rx_ff[j]  <= DW'(cx_ff[1][j]) - DW'(cx_ff[0][j]);
            ry_ff[j]  <= DW'(cy_ff[1][j]) - DW'(cy_ff[0][j]);
            dxp_ff[j] <= DW'(cx_ff[0][j]) - DW'(bxp_ff);
            dxm_ff[j] <= DW'(cx_ff[0][j]) - DW'(bxm_ff);
            dyp_ff[j] <= DW'(cy_ff[0][j]) - DW'(byp_ff);
            dym_ff[j] <= DW'(cy_ff[0][j]) - DW'(bym_ff);
         end
      end
   end

   // Crossing products: determinant, and the numerators of s and t.
   logic signed [EW-1:0]  w2_s, l2_s;
   logic signed [PDW-1:0] pdw [NC];
   logic signed [PDW-1:0] pdl [NC];
   logic signed [PDW-1:0] pnt [NC][NC];
   logic signed [PNW-1:0] pna [NC][NC];
   logic signed [PNW-1:0] pnb [NC][NC];

   assign w2_s = $signed({1'b0, half_width_ff, 1'b0});
   assign l2_s = $signed({1'b0, half_length_ff, 1'b0});

   for (genvar j = 0; j < NC; j++) begin : g_path
      sbx_mul #(.AW(EW), .BW(DW)) u_dw (.clock(clock), .en(adv), .a(w2_s),
                                       .b(rx_ff[j]), .p(pdw[j]));
      sbx_mul #(.AW(EW), .BW(DW)) u_dl (.clock(clock), .en(adv), .a(l2_s),
                                       .b(ry_ff[j]), .p(pdl[j]));
      for (genvar i = 0; i < NC; i++) begin : g_side
         logic signed [DW-1:0] dxi, dyi;
         assign dxi = sbx_pkg::CORNER_XNEG[i] ? dxm_ff[j] : dxp_ff[j];
         assign dyi = sbx_pkg::CORNER_YNEG[i] ? dym_ff[j] : dyp_ff[j];
         if (i % 2 == 0) begin : g_even
            sbx_mul #(.AW(EW), .BW(DW)) u_nt (.clock(clock), .en(adv), .a(w2_s),
                                             .b(dxi), .p(pnt[j][i]));
         end else begin : g_odd
            sbx_mul #(.AW(EW), .BW(DW)) u_nt (.clock(clock), .en(adv), .a(l2_s),
                                             .b(dyi), .p(pnt[j][i]));
         end
         sbx_mul #(.AW(DW), .BW(DW)) u_na (.clock(clock), .en(adv), .a(dxi),
                                          .b(ry_ff[j]), .p(pna[j][i]));
         sbx_mul #(.AW(DW), .BW(DW)) u_nb (.clock(clock), .en(adv), .a(dyi),
                                          .b(rx_ff[j]), .p(pnb[j][i]));
      end
   end

   // Signed determinant and numerators per pair.
   logic signed [KW-1:0] det_ff [NC][NC];
   logic signed [KW-1:0] ns_ff  [NC][NC];
   logic signed [KW-1:0] nt_ff  [NC][NC];

   always_ff @(posedge clock) begin
      logic signed [KW-1:0] dbase;
      if (adv) begin
         for (int j = 0; j < NC; j++) begin
            for (int i = 0; i < NC; i++) begin
               dbase = (i % 2 == 0) ? KW'(pdw[j]) : KW'(pdl[j]);
               det_ff[j][i] <= sbx_pkg::DET_NEG[i] ? -dbase : dbase;
               nt_ff[j][i]  <= sbx_pkg::NT_NEG[i] ? -KW'(pnt[j][i]) : KW'(pnt[j][i]);
               ns_ff[j][i]  <= KW'(pna[j][i]) - KW'(pnb[j][i]);
            end
         end
      end
   end

   // Range test: both numerators lie between zero and the determinant.
   always_comb begin
      logic pos, inside_s, inside_t;
      rsp_hit_in = 1'b0;
      for (int j = 0; j < NC; j++) begin
         for (int i = 0; i < NC; i++) begin
            pos = !det_ff[j][i][KW-1];
            if (pos) begin
               inside_s = !ns_ff[j][i][KW-1] && (ns_ff[j][i] <= det_ff[j][i]);
               inside_t = !nt_ff[j][i][KW-1] && (nt_ff[j][i] <= det_ff[j][i]);
            end else begin
               inside_s = (ns_ff[j][i] <= 0) && (ns_ff[j][i] >= det_ff[j][i]);
               inside_t = (nt_ff[j][i] <= 0) && (nt_ff[j][i] >= det_ff[j][i]);
            end
            if ((det_ff[j][i] != '0) && inside_s && inside_t) begin
               rsp_hit_in = box_ff[ST_SUB];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v_ff[ST_SUB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff <= rsp_hit_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

`ifndef SYNTH
   a_box_only: assert property (@(posedge clock) disable iff (reset)
      adv && v_ff[ST_SUB] && !box_ff[ST_SUB] |=> !rsp_hit)
      else $error("hit reported for an obstacle that is not a box");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      adv && v_ff[ST_SUB] |=> rsp_valid)
      else $error("item left the last stage without a result");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      adv && !v_ff[ST_SUB] |=> !rsp_valid)
      else $error("result appeared without an item behind it");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v_ff))
      else $error("pipeline moved while the result was stalled");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_swept_box_edge_crossing_core.sv =====
// Self-checking testbench for swept_box_edge_crossing_core.
// It compares every hit result with a built-in fixed-point predictor under random idling,
// receiver back-pressure and several box sizes. It depends on sbx_pkg and the core's RTL.
`default_nettype none

module tb_swept_box_edge_crossing_core;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [127:0] wide_type;
   typedef logic signed [sbx_pkg::COORD_W-1:0] coord_type;
   typedef logic [sbx_pkg::ANGLE_W-1:0] angle_type;

   typedef struct {
      coord_type sx, sy, ex, ey, ox, oy;
      angle_type sh, eh;
      logic      is_box;
   } query_type;

   localparam int HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   coord_type req_start_x = '0, req_start_y = '0, req_end_x = '0;
   coord_type req_end_y = '0, req_obstacle_x = '0, req_obstacle_y = '0;
   angle_type req_start_heading = '0, req_end_heading = '0;
   logic req_obstacle_is_box = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [sbx_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [sbx_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   longint half_len_cfg, half_wid_cfg;
   logic expected_hits[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit hold_request = 1'b0;
   bit hold_taken = 1'b0;

   swept_box_edge_crossing_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_start_heading(req_start_heading),
      .req_end_x(req_end_x), .req_end_y(req_end_y), .req_end_heading(req_end_heading),
      .req_obstacle_x(req_obstacle_x), .req_obstacle_y(req_obstacle_y),
      .req_obstacle_is_box(req_obstacle_is_box),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void heading_trig(input angle_type h,
                                        output longint c, output longint s);
      logic [31:0] ang;
      longint x, y, z, dx, dy;
      bit flip;
      ang = {h, 16'h0000};
      flip = (h[15:14] == 2'b01) || (h[15:14] == 2'b10);
      if (flip) begin
         ang = ang + 32'h8000_0000;
      end
      z = longint'(signed'(ang));
      x = longint'(sbx_pkg::CORDIC_GAIN);
      y = 0;
      for (int i = 0; i < sbx_pkg::CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(sbx_pkg::ATAN_TAB[i]);
         end else begin
            x += dx; y -= dy; z += longint'(sbx_pkg::ATAN_TAB[i]);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint round_offset(input longint pos, input longint p, input longint q);
      return pos + ((p - q + (longint'(1) <<< (sbx_pkg::TRIG_BITS - 1))) >>> sbx_pkg::TRIG_BITS);
   endfunction

   function automatic wide_type cross2(input longint ax, input longint ay,
                                       input longint bx, input longint by);
      wide_type wax, way, wbx, wby;
      wax = ax; way = ay; wbx = bx; wby = by;
      return wax * wby - way * wbx;
   endfunction

   function automatic bit segments_cross(input longint px, input longint py,
                                         input longint rx, input longint ry,
                                         input longint qx, input longint qy,
                                         input longint ex, input longint ey);
      wide_type det, ns, nt;
      det = cross2(ex, ey, rx, ry);
      if (det == 0) begin
         return 1'b0;
      end
      ns = cross2(px - qx, py - qy, rx, ry);
      nt = cross2(px - qx, py - qy, ex, ey);
      if (det < 0) begin
         det = -det; ns = -ns; nt = -nt;
      end
      return ns >= 0 && ns <= det && nt >= 0 && nt <= det;
   endfunction

   function automatic logic sweep_hits_box(input query_type qr);
      int sgn_l[4] = '{1, 1, -1, -1};
      int sgn_w[4] = '{1, -1, -1, 1};
      longint cs, ss, ce, se, a, b, px, py, qx, qy;
      longint bx[4], by[4];
      logic hit;
      int n;
      hit = 1'b0;
      if (!qr.is_box) begin
         return 1'b0;
      end
      heading_trig(qr.sh, cs, ss);
      heading_trig(qr.eh, ce, se);
      for (int i = 0; i < 4; i++) begin
         bx[i] = longint'(qr.ox) + sgn_l[i] * half_len_cfg;
         by[i] = longint'(qr.oy) + sgn_w[i] * half_wid_cfg;
      end
      for (int j = 0; j < 4; j++) begin
         a = sgn_l[j] * half_len_cfg;
         b = sgn_w[j] * half_wid_cfg;
         px = round_offset(longint'(qr.sx), a * cs, b * ss);
         py = round_offset(longint'(qr.sy), a * ss, -(b * cs));
         qx = round_offset(longint'(qr.ex), a * ce, b * se);
         qy = round_offset(longint'(qr.ey), a * se, -(b * ce));
         for (int i = 0; i < 4; i++) begin
            n = (i + 1) % 4;
            if (segments_cross(px, py, qx - px, qy - py, bx[i], by[i],
                               bx[n] - bx[i], by[n] - by[i])) begin
               hit = 1'b1;
            end
         end
      end
      return hit;
   endfunction

   task automatic send_query(input query_type qr);
      req_valid <= 1'b1;
      req_start_x <= qr.sx;
      req_start_y <= qr.sy;
      req_start_heading <= qr.sh;
      req_end_x <= qr.ex;
      req_end_y <= qr.ey;
      req_end_heading <= qr.eh;
      req_obstacle_x <= qr.ox;
      req_obstacle_y <= qr.oy;
      req_obstacle_is_box <= qr.is_box;
      do begin
         @(posedge clock);
      end while (req_stall);
      expected_hits = {expected_hits, sweep_hits_box(qr)};
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      pause_sender(1);
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [sbx_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == sbx_pkg::REG_HALF_LENGTH) begin
         half_len_cfg = longint'(data[sbx_pkg::HALF_W-1:0]);
      end else if (idx == sbx_pkg::REG_HALF_WIDTH) begin
         half_wid_cfg = longint'(data[sbx_pkg::HALF_W-1:0]);
      end
      @(posedge clock);
   endtask

   task automatic set_box_size(input logic [31:0] len, input logic [31:0] wid);
      drain_results();
      write_register(sbx_pkg::REG_HALF_LENGTH, len);
      write_register(sbx_pkg::REG_HALF_WIDTH, wid);
   endtask

   function automatic query_type random_query();
      query_type qr;
      longint spread, base_x, base_y;
      spread = 4 * (half_len_cfg + half_wid_cfg) + 1;
      if (spread > 64'h4000_0000) begin
         spread = 64'h4000_0000;
      end
      qr.sh = angle_type'($urandom);
      qr.eh = ($urandom_range(0, 3) == 0) ? qr.sh : angle_type'($urandom);
      qr.is_box = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 9) < 8) begin
         base_x = longint'($signed($urandom)) >>> $urandom_range(1, 12);
         base_y = longint'($signed($urandom)) >>> $urandom_range(1, 12);
         qr.ox = coord_type'(base_x);
         qr.oy = coord_type'(base_y);
         qr.sx = coord_type'(base_x + longint'($urandom) % spread - longint'($urandom) % spread);
         qr.sy = coord_type'(base_y + longint'($urandom) % spread - longint'($urandom) % spread);
         qr.ex = coord_type'(base_x + longint'($urandom) % spread - longint'($urandom) % spread);
         qr.ey = coord_type'(base_y + longint'($urandom) % spread - longint'($urandom) % spread);
         if ($urandom_range(0, 7) == 0) begin
            qr.ex = qr.sx;
            qr.ey = qr.sy;
         end
      end else begin
         qr.sx = $urandom; qr.sy = $urandom; qr.ex = $urandom;
         qr.ey = $urandom; qr.ox = $urandom; qr.oy = $urandom;
      end
      return qr;
   endfunction

   task automatic send_random_burst(input int count);
      int left, burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && left > 0; i++, left--) begin
            send_query(random_query());
         end
         if ($urandom_range(0, 2) != 0) begin
            pause_sender($urandom_range(1, 8));
         end
      end
   endtask

   function automatic query_type make_query(input longint sx, input longint sy,
                                            input int sh, input longint ex,
                                            input longint ey, input int eh,
                                            input longint ox, input longint oy,
                                            input bit is_box);
      query_type qr;
      qr.sx = coord_type'(sx); qr.sy = coord_type'(sy); qr.sh = angle_type'(sh);
      qr.ex = coord_type'(ex); qr.ey = coord_type'(ey); qr.eh = angle_type'(eh);
      qr.ox = coord_type'(ox); qr.oy = coord_type'(oy); qr.is_box = is_box;
      return qr;
   endfunction

   task automatic test_directed_cases();
      longint one;
      one = 64'h1_0000;
      send_query(make_query(-5 * one, 0, 0, 5 * one, 0, 0, 0, 0, 1'b1));
      send_query(make_query(-5 * one, 0, 0, 5 * one, 0, 0, 0, 0, 1'b0));
      send_query(make_query(0, 5 * one, 16384, 0, -5 * one, 16384, 0, 0, 1'b1));
      send_query(make_query(-5 * one, 0, 32768, 5 * one, 0, 49152, 0, 0, 1'b1));
      send_query(make_query(-5 * one, 3 * one, 0, 5 * one, 3 * one, 0, 0, 0, 1'b1));
      send_query(make_query(-4 * one, 2 * one, 0, 4 * one, 2 * one, 0, 0, 0, 1'b1));
      send_query(make_query(-3 * one, 0, 0, -1 * one, 0, 0, 0, 0, 1'b1));
      send_query(make_query(one, one, 65535, one, one, 65535, 0, 0, 1'b1));
      send_query(make_query(-2 * one, -2 * one, 8192, 2 * one, 2 * one, 24576, 0, 0, 1'b1));
      send_query(make_query(-2 * one, 2 * one, 49152, 2 * one, -2 * one, 40960, 0, 0, 1'b1));
      send_query(make_query(-32'sh8000_0000, -32'sh8000_0000, 0,
                            32'sh7fff_ffff, 32'sh7fff_ffff, 65535, 0, 0, 1'b1));
      send_query(make_query(32'sh7fff_ffff, -32'sh8000_0000, 32768,
                            -32'sh8000_0000, 32'sh7fff_ffff, 16384,
                            32'sh7fff_ffff, -32'sh8000_0000, 1'b1));
      send_query(make_query(-1, -1, 65535, -1, -1, 0, -32'sh8000_0000, 32'sh7fff_ffff, 1'b1));
      send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
      send_query(make_query(-32'sh8000_0000, 0, 0, 32'sh7fff_ffff, 0, 0, 0, 0, 1'b1));
      send_query(make_query(0, -32'sh8000_0000, 16384, 0, 32'sh7fff_ffff, 16384, 0, 0, 1'b1));
   endtask

   task automatic test_box_sizes();
      set_box_size(32'd0, 32'd0);
      send_query(make_query(-5 << 16, 0, 0, 5 << 16, 0, 0, 0, 0, 1'b1));
      send_random_burst(40);
      set_box_size(32'h3fff_ffff, 32'h3fff_ffff);
      send_query(make_query(-32'sh8000_0000, 0, 0, 32'sh7fff_ffff, 0, 16384, 0, 0, 1'b1));
      send_random_burst(60);
      set_box_size(32'hffff_ffff, 32'd1);
      send_random_burst(40);
      set_box_size(32'd1, 32'h3fff_ffff);
      send_random_burst(40);
   endtask

   task automatic test_back_pressure();
      set_box_size(32'h0002_0000, 32'h0000_8000);
      hold_request = 1'b1;
      send_random_burst(120);
   endtask

   task automatic test_random_sweeps();
      for (int phase = 0; phase < 6; phase++) begin
         set_box_size($urandom_range(1 << 12, 1 << 20), $urandom_range(1 << 12, 1 << 20));
         send_random_burst(100);
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            case (($time / 1200) % 4)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 9) < 3);
               2: rsp_stall <= (($time / 12) % 5) < 2;
               default: rsp_stall <= ($urandom_range(0, 9) < 7);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Unexpected result item: hit=%b", rsp_hit);
            end
         end else begin
            if (rsp_hit !== expected_hits[0]) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Hit mismatch: expected %b, got %b", expected_hits[0], rsp_hit);
               end
            end
            void'(expected_hits.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[swept_box_edge_crossing_core] ERROR");
         $finish;
      end
   end

   initial begin
      half_len_cfg = 64'h1_0000;
      half_wid_cfg = 64'h1_0000;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      send_random_burst(60);
      test_box_sizes();
      test_back_pressure();
      test_random_sweeps();
      drain_results();
      if (mismatches == 0 && expected_hits.size() == 0) begin
         $display("[swept_box_edge_crossing_core] OK");
      end else begin
         $display("[swept_box_edge_crossing_core] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/sbx_pkg.sv
hdl/sbx_mul.sv
hdl/sbx_cordic.sv
hdl/swept_box_edge_crossing_core.sv
tb/tb_swept_box_edge_crossing_core.sv
